>>> hdl/rotating_think_scheduler_budget_defines.svh
// assertion macros for the rotating think scheduler
`ifndef ROTATING_THINK_SCHEDULER_BUDGET_DEFINES_SVH
`define ROTATING_THINK_SCHEDULER_BUDGET_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define RTSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define RTSB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rtsb_pkg.sv
// shared types and constants of the rotating think scheduler
package rtsb_pkg;

	localparam int TICK_W     = 32;
	localparam int INDEX_W    = 13;
	localparam int TIER_W     = 2;
	localparam int IV_W       = 8;
	localparam int BUDGET_W   = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int NUM_TIERS  = 3;
	localparam int MAX_AGENTS = 8192;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_FULL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_REDUCED  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MINIMAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_FULL       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_REDUCED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_MINIMAL    = 3'd5;

	// tier codes
	localparam logic [TIER_W-1:0] TIER_FULL        = 2'd0;
	localparam logic [TIER_W-1:0] TIER_REDUCED     = 2'd1;
	localparam logic [TIER_W-1:0] TIER_MINIMAL     = 2'd2;
	localparam logic [TIER_W-1:0] TIER_STATISTICAL = 2'd3;

	// decision codes
	localparam logic [1:0] DEC_SKIPPED = 2'd0;
	localparam logic [1:0] DEC_NOT_DUE = 2'd1;
	localparam logic [1:0] DEC_DEFER   = 2'd2;
	localparam logic [1:0] DEC_THINK   = 2'd3;

	// reset values of the registers
	localparam logic [IV_W-1:0]     RST_INTERVAL_FULL    = 8'd1;
	localparam logic [IV_W-1:0]     RST_INTERVAL_REDUCED = 8'd4;
	localparam logic [IV_W-1:0]     RST_INTERVAL_MINIMAL = 8'd16;
	localparam logic [BUDGET_W-1:0] RST_BUDGET           = 14'd8192;

	typedef struct packed {
		logic               start_of_tick;
		logic [TICK_W-1:0]  tick_number;
		logic [INDEX_W-1:0] agent_index;
		logic [TIER_W-1:0]  agent_tier;
		logic [TICK_W-1:0]  last_think;
	} in_item_t;

	typedef struct packed {
		logic [1:0] decision;
		logic       starved;
		logic       over_budget;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

endpackage

>>> hdl/rotating_think_scheduler_budget.sv
// Rotating think scheduler: per-agent due check with per-tier think budget.
//
// One request on the in channel describes one agent of the current tick; one
// result leaves on the out channel for every request, in order. Both channels
// use valid and stall; a request is taken when valid is high and stall low.
// The six registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while the block is idle, as the block itself does
// not enforce it; an index above five is ignored. When a modulo is needed, a
// request passes from acceptance through the setup state, the bit-serial
// remainder unit over the 32-bit tick distance, the decision state and the
// idle state before the next acceptance; statistical agents and intervals of
// at most one skip the remainder unit. The result enters the output register
// when the decision commits; in_stall is high from acceptance until then.
// If the receiver stalls, the finished decision waits in the decision state
// until the output register frees, so no result is lost or repeated.
// Reset loads the register defaults, clears the spent counters, the sticky
// exceeded flag and the output valid, and leaves the block idle.
`include "rotating_think_scheduler_budget_defines.svh"

module rotating_think_scheduler_budget (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  rtsb_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output rtsb_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [rtsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtsb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rtsb_pkg::*;

	localparam int CNT_W = $clog2(TICK_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_W - 1);

	// configuration registers
	logic [IV_W-1:0]     iv_full_q, iv_reduced_q, iv_minimal_q;
	logic [BUDGET_W-1:0] bud_full_q, bud_reduced_q, bud_minimal_q;

	// scheduler state
	logic [BUDGET_W-1:0] spent_q [NUM_TIERS];
	logic                exceeded_q;

	// request and sequencer
	state_t              state_q, state_d;
	in_item_t            req_q;
	logic [IV_W-1:0]     iv_q;
	logic [TICK_W-1:0]   div_q;
	logic [IV_W-1:0]     rem_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic                out_valid_q;
	out_item_t           out_q;

	// control strobes
	logic                accept;
	logic                div_start;
	logic                div_step;
	logic                commit;

	// combinational helpers
	logic [INDEX_W-1:0]  idx;
	logic [TICK_W-1:0]   tick_gap;
	logic [IV_W-1:0]     iv_sel;
	logic [IV_W:0]       trial;
	logic [IV_W:0]       trial_sub;
	logic [BUDGET_W-1:0] spent_cur;
	logic [BUDGET_W-1:0] budget_cur;
	logic                exceeded_cur;
	logic                due;
	logic                starve;
	logic [TICK_W:0]     deadline;
	logic [1:0]          dec;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_full_q     <= RST_INTERVAL_FULL;
			iv_reduced_q  <= RST_INTERVAL_REDUCED;
			iv_minimal_q  <= RST_INTERVAL_MINIMAL;
			bud_full_q    <= RST_BUDGET;
			bud_reduced_q <= RST_BUDGET;
			bud_minimal_q <= RST_BUDGET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL_FULL:    iv_full_q     <= cfg_data[IV_W-1:0];
				REG_INTERVAL_REDUCED: iv_reduced_q  <= cfg_data[IV_W-1:0];
				REG_INTERVAL_MINIMAL: iv_minimal_q  <= cfg_data[IV_W-1:0];
				REG_BUDGET_FULL:      bud_full_q    <= cfg_data[BUDGET_W-1:0];
				REG_BUDGET_REDUCED:   bud_reduced_q <= cfg_data[BUDGET_W-1:0];
				REG_BUDGET_MINIMAL:   bud_minimal_q <= cfg_data[BUDGET_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_PREP;
			S_PREP: begin
				if (req_q.agent_tier == TIER_STATISTICAL || iv_sel <= IV_W'(1))
					state_d = S_DONE;
				else
					state_d = S_DIV;
			end
			S_DIV: if (cnt_q == CNT_LAST) state_d = S_DONE;
			S_DONE: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		accept    = (state_q == S_IDLE) && in_valid;
		div_start = (state_q == S_PREP);
		div_step  = (state_q == S_DIV);
		commit    = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// interval of the request's tier and distance between tick and index
	always_comb begin
		case (req_q.agent_tier)
			TIER_FULL:    iv_sel = iv_full_q;
			TIER_REDUCED: iv_sel = iv_reduced_q;
			default:      iv_sel = iv_minimal_q;
		endcase
		idx = INDEX_W'(32'(req_q.agent_index) % MAX_AGENTS);
		if (req_q.tick_number >= TICK_W'(idx))
			tick_gap = req_q.tick_number - TICK_W'(idx);
		else
			tick_gap = TICK_W'(idx) - req_q.tick_number;
	end

	// remainder step: shift in one dividend bit, subtract if it fits
	always_comb begin
		trial     = {rem_q, div_q[TICK_W-1]};
		trial_sub = trial - {1'b0, iv_q};
	end

	// request capture and remainder unit
	always_ff @(posedge clk) begin
		if (accept) req_q <= in_data;
		if (div_start) begin
			iv_q  <= iv_sel;
			div_q <= tick_gap;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (div_step) begin
			div_q <= {div_q[TICK_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
			if (trial >= {1'b0, iv_q}) rem_q <= trial_sub[IV_W-1:0];
			else                       rem_q <= trial[IV_W-1:0];
		end
	end

	// decision from remainder, budget and starvation deadline
	always_comb begin
		case (req_q.agent_tier)
			TIER_FULL: begin
				spent_cur  = spent_q[0];
				budget_cur = bud_full_q;
			end
			TIER_REDUCED: begin
				spent_cur  = spent_q[1];
				budget_cur = bud_reduced_q;
			end
			default: begin
				spent_cur  = spent_q[2];
				budget_cur = bud_minimal_q;
			end
		endcase
		if (req_q.start_of_tick) begin
			spent_cur    = '0;
			exceeded_cur = 1'b0;
		end else begin
			exceeded_cur = exceeded_q;
		end
		due      = (iv_q <= IV_W'(1)) || (rem_q == '0);
		deadline = {1'b0, req_q.last_think} + (TICK_W + 1)'(iv_q);
		starve   = {1'b0, req_q.tick_number} > deadline;
		if (req_q.agent_tier == TIER_STATISTICAL) dec = DEC_SKIPPED;
		else if (!due)                            dec = DEC_NOT_DUE;
		else if (spent_cur >= budget_cur)         dec = DEC_DEFER;
		else                                      dec = DEC_THINK;
	end

	// spent counters and sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIERS; i++) spent_q[i] <= '0;
			exceeded_q <= 1'b0;
		end else if (commit) begin
			// granted tier counts on, the others clear at the start of a tick
			for (int i = 0; i < NUM_TIERS; i++) begin
				if (dec == DEC_THINK && req_q.agent_tier == TIER_W'(i))
					spent_q[i] <= spent_cur + BUDGET_W'(1);
				else if (req_q.start_of_tick)
					spent_q[i] <= '0;
			end
			exceeded_q <= exceeded_cur || (dec == DEC_DEFER);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (commit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.decision    <= dec;
			out_q.starved     <= (dec == DEC_NOT_DUE) && starve;
			out_q.over_budget <= exceeded_cur || (dec == DEC_DEFER);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`RTSB_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accepted request not held off")
	`RTSB_ASSERT(a_starved_only_not_due, (out_valid && out_data.decision != DEC_NOT_DUE) |-> !out_data.starved, "starved flag on a due or skipped agent")
	`RTSB_ASSERT(a_defer_sets_flag, (out_valid && out_data.decision == DEC_DEFER) |-> out_data.over_budget, "deferral without over budget flag")
	`RTSB_ASSERT_ALWAYS(a_reset_no_output, !arst_n |-> !out_valid, "output valid during reset")

endmodule
